[hdl/video_register_port_and_vram_map_defines.svh]
// ----------------------------------------------------------------------------
// video register port assertion macros
// shared concurrent assertion forms, clocked on clock, quiet during reset
// ----------------------------------------------------------------------------
`ifndef VIDEO_REGISTER_PORT_AND_VRAM_MAP_DEFINES_SVH
`define VIDEO_REGISTER_PORT_AND_VRAM_MAP_DEFINES_SVH

// same-cycle implication
`define VRPVM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define VRPVM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/vrpvm_pkg.sv]
// ----------------------------------------------------------------------------
// vrpvm_pkg
// constants, codes and command types of the video register port
// ----------------------------------------------------------------------------
package vrpvm_pkg;

   // memory sizes
   localparam int NAMETABLE_BYTES = 1024;
   localparam int PALETTE_BYTES   = 32;

   // operation codes
   localparam logic [1:0] FUNC_READ   = 2'd0;
   localparam logic [1:0] FUNC_WRITE  = 2'd1;
   localparam logic [1:0] FUNC_VSTART = 2'd2;
   localparam logic [1:0] FUNC_VEND   = 2'd3;

   // register indexes
   localparam logic [2:0] REG_CTRL   = 3'd0;
   localparam logic [2:0] REG_MASK   = 3'd1;
   localparam logic [2:0] REG_STATUS = 3'd2;
   localparam logic [2:0] REG_SCROLL = 3'd5;
   localparam logic [2:0] REG_ADDR   = 3'd6;
   localparam logic [2:0] REG_DATA   = 3'd7;

   // video map boundary for palette space
   localparam logic [13:0] PAL_BASE = 14'h3F00;

   // controller to datapath commands
   typedef struct packed {
      logic clear_en;
      logic load;
      logic commit;
   } vrpvm_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clear_last;
   } vrpvm_sts_type;

endpackage

[hdl/vrpvm_if.sv]
// ----------------------------------------------------------------------------
// vrpvm channel interfaces
// request, response and csr write channels with valid/ready handshake
// ----------------------------------------------------------------------------

// request channel
interface vrpvm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [2:0] reg_index;
   logic [7:0] write_data;
   logic [7:0] chr_read_data;

   modport source (output valid, func, reg_index, write_data, chr_read_data,
                   input ready);
   modport sink   (input valid, func, reg_index, write_data, chr_read_data,
                   output ready);
endinterface

// response channel
interface vrpvm_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  read_data;
   logic        chr_write_en;
   logic [13:0] chr_addr;
   logic [7:0]  chr_write_data;
   logic        nmi;
   logic [14:0] vram_addr;

   modport source (output valid, read_data, chr_write_en, chr_addr, chr_write_data,
                   nmi, vram_addr, input ready);
   modport sink   (input valid, read_data, chr_write_en, chr_addr, chr_write_data,
                   nmi, vram_addr, output ready);
endinterface

// csr write channel
interface vrpvm_csr_if;
   logic valid;
   logic ready;
   logic mirror_mode;

   modport source (output valid, mirror_mode, input ready);
   modport sink   (input valid, mirror_mode, output ready);
endinterface

[hdl/vrpvm_ctrl.sv]
// ----------------------------------------------------------------------------
// vrpvm_ctrl
// sequencer: memory clear after reset, accept, execute and response slot
// ----------------------------------------------------------------------------
`include "video_register_port_and_vram_map_defines.svh"

module vrpvm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  vrpvm_pkg::vrpvm_sts_type sts,
   output vrpvm_pkg::vrpvm_cmd_type cmd
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   // handshake and commands
   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      cmd.clear_en = (state_ff == ST_CLEAR);
      cmd.load     = req_valid && req_ready;
      cmd.commit   = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (cmd.load) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (cmd.commit) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // response slot occupancy
   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // checks
   `VRPVM_ASSERT_NEXT(a_load_to_exec, cmd.load, state_ff == ST_EXEC, "load did not enter execute")
   `VRPVM_ASSERT_NEXT(a_commit_fills, cmd.commit, rsp_valid_ff, "commit left response slot empty")
   `VRPVM_ASSERT_NOW(a_clear_blocks, state_ff == ST_CLEAR, !req_ready && !cmd.commit, "transfer during clear")
   `VRPVM_ASSERT_NEXT(a_stall_holds, (state_ff == ST_EXEC) && !cmd.commit, state_ff == ST_EXEC, "execute dropped while stalled")

endmodule

[hdl/vrpvm_datapath.sv]
// ----------------------------------------------------------------------------
// vrpvm_datapath
// register file, address latches, nametable and palette memories, result register
// ----------------------------------------------------------------------------
module vrpvm_datapath #(
   parameter int NAMETABLE_BYTES = vrpvm_pkg::NAMETABLE_BYTES,
   parameter int PALETTE_BYTES   = vrpvm_pkg::PALETTE_BYTES
) (
   input  logic                     clock,
   input  logic                     reset,
   input  vrpvm_pkg::vrpvm_cmd_type cmd,
   output vrpvm_pkg::vrpvm_sts_type sts,
   input  logic                     csr_valid,
   input  logic                     csr_mirror_mode,
   input  logic [1:0]               req_func,
   input  logic [2:0]               req_reg_index,
   input  logic [7:0]               req_write_data,
   input  logic [7:0]               req_chr_read_data,
   output logic [7:0]               rsp_read_data,
   output logic                     rsp_chr_write_en,
   output logic [13:0]              rsp_chr_addr,
   output logic [7:0]               rsp_chr_write_data,
   output logic                     rsp_nmi,
   output logic [14:0]              rsp_vram_addr
);

   localparam int NT_DEPTH = 2 * NAMETABLE_BYTES;
   localparam int NTW      = $clog2(NAMETABLE_BYTES);
   localparam int NTAW     = $clog2(NT_DEPTH);
   localparam int PW       = $clog2(PALETTE_BYTES);

   // architectural state
   logic        mirror_ff;
   logic [7:0]  ctrl_ff,   ctrl_in;
   logic [7:0]  mask_ff,   mask_in;
   logic [2:0]  status_ff, status_in;
   logic [14:0] cur_ff,    cur_in;
   logic [14:0] temp_ff,   temp_in;
   logic [2:0]  fine_x_ff, fine_x_in;
   logic        toggle_ff, toggle_in;
   logic [7:0]  rbuf_ff,   rbuf_in;

   // latched request
   logic [1:0]  func_ff;
   logic [2:0]  reg_ff;
   logic [7:0]  wdata_ff;
   logic [7:0]  chr_q_ff;

   // memories
   logic [7:0]  nt_mem  [NT_DEPTH];
   logic [7:0]  pal_mem [PALETTE_BYTES];
   logic [7:0]  nt_q_ff;
   logic [7:0]  pal_q_ff;
   logic [NTAW-1:0] clr_cnt_ff;

   // result register
   logic [7:0]  rd_ff,    rd_in;
   logic        cwe_ff,   cwe_in;
   logic [13:0] caddr_ff, caddr_in;
   logic [7:0]  cwd_ff,   cwd_in;
   logic        nmi_ff,   nmi_in;
   logic [14:0] vaddr_ff;

   // address decode
   logic [13:0]     va;
   logic            va_chr;
   logic            va_pal;
   logic [NTAW-1:0] nt_idx;
   logic [PW-1:0]   pal_idx;
   logic [14:0]     cur_inc;
   logic [7:0]      fetch;
   logic            nt_we;
   logic            pal_we;
   logic [NTAW-1:0] nt_waddr;
   logic [PW-1:0]   pal_waddr;
   logic [7:0]      mem_wdata;
   logic            data_write;

   // video map of the current address
   always_comb begin
      va      = cur_ff[13:0];
      va_chr  = !va[13];
      va_pal  = (va >= vrpvm_pkg::PAL_BASE);
      nt_idx  = {(mirror_ff ? va[11] : va[10]), va[NTW-1:0]};
      pal_idx = va[PW-1:0];
      // backdrop entries of sprite palettes alias the background ones
      if (pal_idx[PW-1] && (pal_idx[1:0] == 2'b00)) pal_idx[PW-1] = 1'b0;
      cur_inc = cur_ff + (ctrl_ff[2] ? 15'd32 : 15'd1);
      fetch   = va_chr ? chr_q_ff : (va_pal ? pal_q_ff : nt_q_ff);
   end

   // step of one request
   always_comb begin
      ctrl_in    = ctrl_ff;
      mask_in    = mask_ff;
      status_in  = status_ff;
      cur_in     = cur_ff;
      temp_in    = temp_ff;
      fine_x_in  = fine_x_ff;
      toggle_in  = toggle_ff;
      rbuf_in    = rbuf_ff;
      rd_in      = 8'd0;
      cwe_in     = 1'b0;
      caddr_in   = 14'd0;
      cwd_in     = 8'd0;
      nmi_in     = 1'b0;
      data_write = 1'b0;
      unique case (func_ff)
         vrpvm_pkg::FUNC_READ: begin
            if (reg_ff == vrpvm_pkg::REG_STATUS) begin
               rd_in        = {status_ff, rbuf_ff[4:0]};
               status_in[2] = 1'b0;
               toggle_in    = 1'b0;
            end else if (reg_ff == vrpvm_pkg::REG_DATA) begin
               rbuf_in  = fetch;
               rd_in    = va_pal ? fetch : rbuf_ff;
               caddr_in = va_chr ? va : 14'd0;
               cur_in   = cur_inc;
            end
         end
         vrpvm_pkg::FUNC_WRITE: begin
            unique case (reg_ff)
               vrpvm_pkg::REG_CTRL: begin
                  ctrl_in        = wdata_ff;
                  temp_in[11:10] = wdata_ff[1:0];
               end
               vrpvm_pkg::REG_MASK: begin
                  mask_in = wdata_ff;
               end
               vrpvm_pkg::REG_SCROLL: begin
                  if (!toggle_ff) begin
                     temp_in[4:0] = wdata_ff[7:3];
                     fine_x_in    = wdata_ff[2:0];
                     toggle_in    = 1'b1;
                  end else begin
                     temp_in[14:12] = wdata_ff[2:0];
                     temp_in[9:5]   = wdata_ff[7:3];
                     toggle_in      = 1'b0;
                  end
               end
               vrpvm_pkg::REG_ADDR: begin
                  if (!toggle_ff) begin
                     temp_in[14]   = 1'b0;
                     temp_in[13:8] = wdata_ff[5:0];
                     toggle_in     = 1'b1;
                  end else begin
                     temp_in[7:0] = wdata_ff;
                     cur_in       = {temp_ff[14:8], wdata_ff};
                     toggle_in    = 1'b0;
                  end
               end
               vrpvm_pkg::REG_DATA: begin
                  data_write = 1'b1;
                  if (va_chr) begin
                     cwe_in   = 1'b1;
                     caddr_in = va;
                     cwd_in   = wdata_ff;
                  end
                  cur_in = cur_inc;
               end
               default: begin
               end
            endcase
         end
         vrpvm_pkg::FUNC_VSTART: begin
            status_in[2] = 1'b1;
            nmi_in       = ctrl_ff[7];
         end
         vrpvm_pkg::FUNC_VEND: begin
            status_in = 3'd0;
         end
         default: begin
         end
      endcase
   end

   // memory write port: clearing sweep or data port write
   always_comb begin
      nt_waddr  = cmd.clear_en ? clr_cnt_ff : nt_idx;
      pal_waddr = cmd.clear_en ? clr_cnt_ff[PW-1:0] : pal_idx;
      mem_wdata = cmd.clear_en ? 8'd0 : wdata_ff;
      nt_we     = cmd.clear_en || (cmd.commit && data_write && !va_chr && !va_pal);
      pal_we    = cmd.clear_en || (cmd.commit && data_write && va_pal);
      sts.clear_last = (clr_cnt_ff == NTAW'(NT_DEPTH - 1));
   end

   // nametable memory
   always_ff @(posedge clock) begin
      if (nt_we) nt_mem[nt_waddr] <= mem_wdata;
      if (cmd.load) nt_q_ff <= nt_mem[nt_idx];
   end

   // palette memory
   always_ff @(posedge clock) begin
      if (pal_we) pal_mem[pal_waddr] <= mem_wdata;
      if (cmd.load) pal_q_ff <= pal_mem[pal_idx];
   end

   // clear sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_en) begin
         clr_cnt_ff <= clr_cnt_ff + NTAW'(1);
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         reg_ff   <= req_reg_index;
         wdata_ff <= req_write_data;
         chr_q_ff <= req_chr_read_data;
      end
   end

   // architectural registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mirror_ff <= 1'b0;
         ctrl_ff   <= 8'd0;
         mask_ff   <= 8'd0;
         status_ff <= 3'd0;
         cur_ff    <= 15'd0;
         temp_ff   <= 15'd0;
         fine_x_ff <= 3'd0;
         toggle_ff <= 1'b0;
         rbuf_ff   <= 8'd0;
      end else begin
         if (csr_valid) mirror_ff <= csr_mirror_mode;
         if (cmd.commit) begin
            ctrl_ff   <= ctrl_in;
            mask_ff   <= mask_in;
            status_ff <= status_in;
            cur_ff    <= cur_in;
            temp_ff   <= temp_in;
            fine_x_ff <= fine_x_in;
            toggle_ff <= toggle_in;
            rbuf_ff   <= rbuf_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rd_ff    <= rd_in;
         cwe_ff   <= cwe_in;
         caddr_ff <= caddr_in;
         cwd_ff   <= cwd_in;
         nmi_ff   <= nmi_in;
         vaddr_ff <= cur_in;
      end
   end

   assign rsp_read_data      = rd_ff;
   assign rsp_chr_write_en   = cwe_ff;
   assign rsp_chr_addr       = caddr_ff;
   assign rsp_chr_write_data = cwd_ff;
   assign rsp_nmi            = nmi_ff;
   assign rsp_vram_addr      = vaddr_ff;

endmodule

[hdl/video_register_port_and_vram_map.sv]
// a request is taken only in idle, then executed, and its response is registered into the response slot
// a new request is not taken until the previous one has committed its response
// a full response slot holds the next request in execute until the slot drains
// reset: synchronous; then a clearing pass over all 2 * NAMETABLE_BYTES (2048) nametable addresses zeroes both
// memories, taking no requests; csr writes are taken at all times
// ----------------------------------------------------------------------------
// video_register_port_and_vram_map
// cpu register window and video memory map with nametable and palette storage
// ----------------------------------------------------------------------------
module video_register_port_and_vram_map #(
   parameter int NAMETABLE_BYTES = vrpvm_pkg::NAMETABLE_BYTES,
   parameter int PALETTE_BYTES   = vrpvm_pkg::PALETTE_BYTES
) (
   input logic         clock,
   input logic         reset,
   vrpvm_req_if.sink   req_bus,
   vrpvm_rsp_if.source rsp_bus,
   vrpvm_csr_if.sink   csr_bus
);

   vrpvm_pkg::vrpvm_cmd_type cmd;
   vrpvm_pkg::vrpvm_sts_type sts;

   // csr writes never stall
   assign csr_bus.ready = 1'b1;

   // sequencer
   vrpvm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // registers and memories
   vrpvm_datapath #(
      .NAMETABLE_BYTES (NAMETABLE_BYTES),
      .PALETTE_BYTES   (PALETTE_BYTES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .csr_valid          (csr_bus.valid),
      .csr_mirror_mode    (csr_bus.mirror_mode),
      .req_func           (req_bus.func),
      .req_reg_index      (req_bus.reg_index),
      .req_write_data     (req_bus.write_data),
      .req_chr_read_data  (req_bus.chr_read_data),
      .rsp_read_data      (rsp_bus.read_data),
      .rsp_chr_write_en   (rsp_bus.chr_write_en),
      .rsp_chr_addr       (rsp_bus.chr_addr),
      .rsp_chr_write_data (rsp_bus.chr_write_data),
      .rsp_nmi            (rsp_bus.nmi),
      .rsp_vram_addr      (rsp_bus.vram_addr)
   );

endmodule
